>>> sv/fspu_pkg.sv
// ----------------------------------------------------------------------------
// fspu_pkg
// Shared widths, register codes, arctangent table and CORDIC seed, step and
// rounding functions for the four-step phase unwrapping pipeline.
// ----------------------------------------------------------------------------
package fspu_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int REG_BITS        = 11;
  localparam int ORDER_BITS      = 12;
  localparam int GUARD_BITS      = 24;
  localparam int CORDIC_STEPS    = PHASE_FRAC_BITS + 4;
  localparam int TAB_LEN         = 32;
  localparam int ANGLE_BITS      = 32;
  // difference is SAMPLE_BITS+1 signed, CORDIC gain and sqrt(2) need 2 more
  localparam int XW              = SAMPLE_BITS + GUARD_BITS + 3;
  localparam int UNWRAP_BITS     = PHASE_FRAC_BITS + ORDER_BITS;
  localparam int PROD_BITS       = REG_BITS + PHASE_FRAC_BITS;
  localparam int CFG_INDEX_BITS  = 1;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_HORIZONTAL = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VERTICAL   = 1'b1;

  // atan(2^-i) in turns, Q0.32, round to nearest
  localparam logic [ANGLE_BITS-1:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // One vectoring rotation state (x, y, accumulated angle)
  typedef struct packed {
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic [ANGLE_BITS-1:0]   z;
  } rot_t;

  // Both phase sets and the selected period travel together
  typedef struct packed {
    rot_t                fine;
    rot_t                coarse;
    logic [REG_BITS-1:0] period;
  } cstage_t;

  // Seed the rotation from four samples: fold x<0 into the right half plane
  function automatic rot_t cordic_seed(input logic [SAMPLE_BITS-1:0] a0,
                                       input logic [SAMPLE_BITS-1:0] a1,
                                       input logic [SAMPLE_BITS-1:0] a2,
                                       input logic [SAMPLE_BITS-1:0] a3);
    logic signed [SAMPLE_BITS:0] dx;
    logic signed [SAMPLE_BITS:0] dy;
    logic signed [XW-1:0]        xs;
    logic signed [XW-1:0]        ys;
    rot_t                        r;
    dx = $signed({1'b0, a0}) - $signed({1'b0, a2});
    dy = $signed({1'b0, a1}) - $signed({1'b0, a3});
    xs = XW'(dx) <<< GUARD_BITS;
    ys = XW'(dy) <<< GUARD_BITS;
    if (dx < 0) begin
      r.x = -xs;
      r.y = -ys;
      r.z = '0;
    end else begin
      r.x = xs;
      r.y = ys;
      r.z = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    end
    return r;
  endfunction

  // One micro-rotation; no move while y is exactly zero
  function automatic rot_t cordic_step(input rot_t r, input int i);
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    rot_t                 o;
    dx = r.y >>> i;
    dy = r.x >>> i;
    o  = r;
    if (r.y > 0) begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + ATAN_TAB[i];
    end else if (r.y < 0) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - ATAN_TAB[i];
    end
    return o;
  endfunction

  // Angle to Q0.F turns, round half up, full turn wraps
  function automatic logic [PHASE_FRAC_BITS-1:0] angle_round(
      input logic [ANGLE_BITS-1:0] z);
    logic [ANGLE_BITS-1:0] s;
    s = z + (ANGLE_BITS'(1) << (ANGLE_BITS - 1 - PHASE_FRAC_BITS));
    return s[ANGLE_BITS-1 -: PHASE_FRAC_BITS];
  endfunction

endpackage

>>> sv/four_step_phase_unwrap.sv
// ----------------------------------------------------------------------------
// four_step_phase_unwrap
// Four-step phase demodulation of a fine and a coarse fringe set per pixel,
// with two-frequency temporal unwrapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel per transaction:
//   the axis select and four fine plus four coarse intensities.
//   Output channel (out_valid / out_stall) returns one transaction per pixel
//   with the wrapped fine phase, the fringe order and the unwrapped phase.
//   Configuration writes (cfg_valid / cfg_ready, always ready) set the
//   horizontal and vertical period counts; write them only while idle.
// Pipeline:
//   One seed stage, one stage per CORDIC micro-rotation, then rounding, the
//   period multiply and the order/unwrap stage. One pixel is accepted every
//   cycle unless in_stall is raised.
// Stall:
//   Each full stage holds while the stage after it is held, so bubbles
//   are squeezed out; in_stall rises only when every stage is full and the
//   output is stalled. Nothing is dropped or repeated.
// Reset:
//   rst clears all stage valid bits and sets both period registers to 16.
// ----------------------------------------------------------------------------
module four_step_phase_unwrap (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [fspu_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [fspu_pkg::REG_BITS-1:0]            cfg_data,
  // pixel input
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic                                     action,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         fine_sample0,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         fine_sample1,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         fine_sample2,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         fine_sample3,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         coarse_sample0,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         coarse_sample1,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         coarse_sample2,
  input  logic [fspu_pkg::SAMPLE_BITS-1:0]         coarse_sample3,
  // result output
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [fspu_pkg::PHASE_FRAC_BITS-1:0]     wrapped_phase,
  output logic signed [fspu_pkg::ORDER_BITS-1:0]   fringe_order,
  output logic signed [fspu_pkg::UNWRAP_BITS-1:0]  unwrapped_phase
);

  localparam int STEPS  = fspu_pkg::CORDIC_STEPS;
  localparam int NST    = STEPS + 4;
  localparam int S_RND  = STEPS + 1;
  localparam int S_MUL  = STEPS + 2;
  localparam int S_OUT  = STEPS + 3;
  localparam int F      = fspu_pkg::PHASE_FRAC_BITS;
  localparam int VW     = fspu_pkg::PROD_BITS + 1;

  // period registers
  logic [fspu_pkg::REG_BITS-1:0] horizontal_periods;
  logic [fspu_pkg::REG_BITS-1:0] vertical_periods;

  // stage valid bits and ready chain
  logic [NST-1:0] vld;
  logic [NST:0]   rdy;

  // pipeline payload
  fspu_pkg::cstage_t                   cs [STEPS+1];
  logic [F-1:0]                        rnd_fine;
  logic [F-1:0]                        rnd_coarse;
  logic [fspu_pkg::REG_BITS-1:0]       rnd_period;
  logic [fspu_pkg::PROD_BITS-1:0]      mul_prod;
  logic [F-1:0]                        mul_fine;
  logic [F-1:0]                        out_fine;
  logic signed [fspu_pkg::ORDER_BITS-1:0]  out_order;
  logic signed [fspu_pkg::UNWRAP_BITS-1:0] out_unwrap;

  fspu_pkg::cstage_t                   seed_next;
  logic signed [VW-1:0]                v_next;
  logic [VW-1:0]                       mag_next;
  logic [VW-1:0]                       rmag_next;
  logic [fspu_pkg::ORDER_BITS-1:0]     kmag_next;
  logic signed [fspu_pkg::ORDER_BITS-1:0]  order_next;
  logic signed [fspu_pkg::UNWRAP_BITS-1:0] unwrap_next;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      horizontal_periods <= fspu_pkg::REG_BITS'(16);
      vertical_periods   <= fspu_pkg::REG_BITS'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fspu_pkg::REG_HORIZONTAL: horizontal_periods <= cfg_data;
        fspu_pkg::REG_VERTICAL:   vertical_periods   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ready ripples back: a stage moves when empty or when the next one moves
  assign rdy[NST] = !out_stall;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_stall = !rdy[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // seed stage: differences, half-plane fold, period select
  always_comb begin
    seed_next.fine   = fspu_pkg::cordic_seed(fine_sample0, fine_sample1,
                                             fine_sample2, fine_sample3);
    seed_next.coarse = fspu_pkg::cordic_seed(coarse_sample0, coarse_sample1,
                                             coarse_sample2, coarse_sample3);
    seed_next.period = action ? vertical_periods : horizontal_periods;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      cs[0] <= seed_next;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rdy[i+1]) begin
        cs[i+1].fine   <= fspu_pkg::cordic_step(cs[i].fine, i);
        cs[i+1].coarse <= fspu_pkg::cordic_step(cs[i].coarse, i);
        cs[i+1].period <= cs[i].period;
      end
    end
  end

  // round angles to Q0.F turns
  always_ff @(posedge clk) begin
    if (rdy[S_RND]) begin
      rnd_fine   <= fspu_pkg::angle_round(cs[STEPS].fine.z);
      rnd_coarse <= fspu_pkg::angle_round(cs[STEPS].coarse.z);
      rnd_period <= cs[STEPS].period;
    end
  end

  // period times coarse phase
  always_ff @(posedge clk) begin
    if (rdy[S_MUL]) begin
      mul_prod <= fspu_pkg::PROD_BITS'(rnd_period) * fspu_pkg::PROD_BITS'(rnd_coarse);
      mul_fine <= rnd_fine;
    end
  end

  // fringe order: round half away from zero, then unwrapped phase
  always_comb begin
    v_next    = $signed({1'b0, mul_prod}) - $signed(VW'(mul_fine));
    mag_next  = (v_next < 0) ? VW'(-v_next) : VW'(v_next);
    rmag_next = mag_next + (VW'(1) << (F - 1));
    kmag_next = fspu_pkg::ORDER_BITS'(rmag_next >> F);
    order_next = (v_next < 0) ? -$signed(kmag_next) : $signed(kmag_next);
    unwrap_next = $signed({order_next, mul_fine});
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      out_fine   <= mul_fine;
      out_order  <= order_next;
      out_unwrap <= unwrap_next;
    end
  end

  assign out_valid       = vld[NST-1];
  assign wrapped_phase   = out_fine;
  assign fringe_order    = out_order;
  assign unwrapped_phase = out_unwrap;

endmodule

>>> sv/four_step_phase_unwrap_checker.sv
// ----------------------------------------------------------------------------
// four_step_phase_unwrap_checker
// Port-level checks for the phase unwrapping pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module four_step_phase_unwrap_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    cfg_ready,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic [fspu_pkg::PHASE_FRAC_BITS-1:0]    wrapped_phase,
  input logic signed [fspu_pkg::ORDER_BITS-1:0]  fringe_order,
  input logic signed [fspu_pkg::UNWRAP_BITS-1:0] unwrapped_phase
);

  // an empty output stage means the pipeline can always take a pixel
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage empty");

  // unwrapped phase splits into order and wrapped phase
  a_unwrap_split: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (unwrapped_phase[fspu_pkg::PHASE_FRAC_BITS-1:0] == wrapped_phase)
                  && (unwrapped_phase[fspu_pkg::UNWRAP_BITS-1:fspu_pkg::PHASE_FRAC_BITS]
                      == fringe_order))
    else $error("unwrapped phase inconsistent with order and wrapped phase");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(unwrapped_phase))
    else $error("stalled result changed");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind four_step_phase_unwrap four_step_phase_unwrap_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_ready       (cfg_ready),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .wrapped_phase   (wrapped_phase),
  .fringe_order    (fringe_order),
  .unwrapped_phase (unwrapped_phase)
);
